// ----- sv/base64_stream_decoder_defines.svh -----
// Assertion macros for the base64 stream decoder.
// Used by the top level; no other dependencies.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// same-cycle implication
`define B64SD_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("b64sd assertion failed");

// next-cycle implication
`define B64SD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("b64sd assertion failed");

`endif

// ----- sv/b64sd_pkg.sv -----
// Shared types, constants and the character map of the base64 stream decoder.
// No dependencies.
package b64sd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CmpW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam int MaxResults = 3;

  localparam logic [7:0] CharTerm  = 8'h00;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;
  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharUA    = 8'h41;
  localparam logic [7:0] CharUZ    = 8'h5A;
  localparam logic [7:0] CharLA    = 8'h61;
  localparam logic [7:0] CharLZ    = 8'h7A;

  localparam logic [5:0] CodePlus  = 6'd62;
  localparam logic [5:0] CodeSlash = 6'd63;
  localparam logic [5:0] CodeDigit = 6'd52;
  localparam logic [5:0] CodeLower = 6'd26;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        run_last;
    logic        message_end;
    logic [15:0] byte_total;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] ent;
    logic [1:0]               count;
  } bundle_t;

  // 12-bit sextet value; all ones stands for an in-range character with no entry
  function automatic logic [11:0] map_char(input logic [7:0] c);
    logic [11:0] v;
    case (c) inside
      CharPlus:        v = {6'b0, CodePlus};
      CharSlash:       v = {6'b0, CodeSlash};
      [Char0:Char9]:   v = {6'b0, 6'(c - Char0) + CodeDigit};
      CharPad:         v = '0;
      [CharUA:CharUZ]: v = {6'b0, 6'(c - CharUA)};
      [CharLA:CharLZ]: v = {6'b0, 6'(c - CharLA) + CodeLower};
      [CharPlus:CharLZ]: v = '1;
      default:         v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/b64sd_decode.sv -----
// Group state, character mapping, byte assembly and limit check.
// Depends on b64sd_pkg.
module b64sd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [7:0]          ch,
  input  logic [15:0]         limit,
  output b64sd_pkg::bundle_t  res
);

  logic [7:0]                       held [3];
  logic [1:0]                       pos;
  logic [b64sd_pkg::COUNT_BITS-1:0] cnt;
  logic                             lim;

  logic [7:0]                       held_next [3];
  logic [1:0]                       pos_next;
  logic [b64sd_pkg::COUNT_BITS-1:0] cnt_next;
  logic                             lim_next;

  logic                             term, group_go;
  logic [7:0]                       c2, c3, c4;
  logic [11:0]                      v1, v2, v3, v4, t0, t1, t2;
  logic [7:0]                       bytes [3];
  logic [1:0]                       k, n;
  logic [2:0]                       en;
  logic [b64sd_pkg::CmpW-1:0]       sum0 [3];
  logic [b64sd_pkg::CmpW-1:0]       sum1 [3];

  always_comb begin
    term = (ch == b64sd_pkg::CharTerm);
    c2 = (!term || pos > 2'd1) ? held[1] : 8'h00;
    c3 = (!term || pos > 2'd2) ? held[2] : 8'h00;
    c4 = term ? 8'h00 : ch;
    v1 = b64sd_pkg::map_char(held[0]);
    v2 = b64sd_pkg::map_char(c2);
    v3 = b64sd_pkg::map_char(c3);
    v4 = b64sd_pkg::map_char(c4);
    t0 = (v1 << 2) | (v2 >> 4);
    t1 = (v2 << 4) | (v3 >> 2);
    t2 = (v3 << 6) | v4;
    bytes[0] = t0[7:0];
    bytes[1] = t1[7:0];
    bytes[2] = t2[7:0];

    group_go = term ? (pos != 2'd0 && !lim) : (!lim && pos == 2'd3);
    if (!group_go) begin
      k = 2'd0;
    end else if (c3 == b64sd_pkg::CharPad) begin
      k = 2'd1;
    end else if (c4 == b64sd_pkg::CharPad) begin
      k = 2'd2;
    end else begin
      k = 2'd3;
    end

    for (int j = 0; j < b64sd_pkg::MaxResults; j++) begin
      sum0[j] = b64sd_pkg::CmpW'(cnt) + b64sd_pkg::CmpW'(j);
      sum1[j] = b64sd_pkg::CmpW'(cnt) + b64sd_pkg::CmpW'(j + 1);
      en[j] = (sum0[j] < b64sd_pkg::CmpW'(limit)) &&
              (sum0[j] < b64sd_pkg::CmpW'(b64sd_pkg::CountMax));
    end
    en[0] = en[0] && !lim;
    en[1] = en[1] && en[0];
    en[2] = en[2] && en[1];

    n = 2'd0;
    if (k >= 2'd1 && en[0]) n = 2'd1;
    if (k >= 2'd2 && en[1]) n = 2'd2;
    if (k >= 2'd3 && en[2]) n = 2'd3;

    for (int j = 0; j < b64sd_pkg::MaxResults; j++) begin
      res.ent[j].data_byte   = bytes[j];
      res.ent[j].byte_valid  = 1'b1;
      res.ent[j].run_last    = (2'(j + 1) == n);
      res.ent[j].message_end = term && (2'(j + 1) == n);
      res.ent[j].byte_total  = sum1[j][15:0];
    end
    res.count = n;
    if (term && n == 2'd0) begin
      res.ent[0].data_byte   = 8'h00;
      res.ent[0].byte_valid  = 1'b0;
      res.ent[0].run_last    = 1'b1;
      res.ent[0].message_end = 1'b1;
      res.ent[0].byte_total  = sum0[0][15:0];
      res.count              = 2'd1;
    end

    held_next = held;
    pos_next  = pos;
    cnt_next  = cnt;
    lim_next  = lim;
    if (term) begin
      held_next = '{default: 8'h00};
      pos_next  = 2'd0;
      cnt_next  = '0;
      lim_next  = 1'b0;
    end else if (!lim) begin
      if (pos != 2'd3) begin
        for (int i = 0; i < 3; i++) begin
          if (pos == 2'(i)) held_next[i] = ch;
        end
        pos_next = pos + 2'd1;
      end else begin
        held_next = '{default: 8'h00};
        pos_next  = 2'd0;
        cnt_next  = cnt + b64sd_pkg::COUNT_BITS'(n);
        lim_next  = (n < k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '{default: 8'h00};
      pos  <= 2'd0;
      cnt  <= '0;
      lim  <= 1'b0;
    end else if (go) begin
      held <= held_next;
      pos  <= pos_next;
      cnt  <= cnt_next;
      lim  <= lim_next;
    end
  end

endmodule

// ----- sv/b64sd_out.sv -----
// Result buffer: holds the up to three results of one character and
// hands one out per cycle unless stalled. Depends on b64sd_pkg.
module b64sd_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  b64sd_pkg::bundle_t  res,
  input  logic                stall,
  output logic                valid,
  output logic                free,
  output b64sd_pkg::result_t  cur
);

  b64sd_pkg::result_t [b64sd_pkg::MaxResults-1:0] ent;
  logic [1:0] rem;
  logic [1:0] ptr;
  logic       take;

  assign valid = (rem != 2'd0);
  assign take  = valid && !stall;
  assign free  = (rem == 2'd0) || (rem == 2'd1 && !stall);
  assign cur   = ent[ptr];

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= res.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      ptr <= 2'd0;
    end else if (load) begin
      rem <= res.count;
      ptr <= 2'd0;
    end else if (take) begin
      rem <= rem - 2'd1;
      ptr <= ptr + 2'd1;
    end
  end

endmodule

// ----- sv/base64_stream_decoder.sv -----
// Base64 stream decoder top level: input register, limit register, decoder, result buffer.
// Depends on b64sd_pkg, b64sd_decode, b64sd_out and base64_stream_decoder_defines.svh.
//
// Takes one text character per cycle, unless text_stall is high, into an input
// register; the decoder updates the group state from that register and writes the
// bytes of a completed group (or the terminator's flush) into a three-entry result
// buffer, which gives one result transaction per cycle while result_stall is low. A
// character that yields no result moves on even while the buffer is busy; one that
// yields n results needs the buffer drained first, so a full group holds the result
// port while the three following characters move on: sustained rate is one character
// per cycle when the result side does not stall. A character's first result passes
// through the input register and then the result buffer registers. output_limit is
// written through its own channel, always ready; the user must write it only while
// the decoder is idle, and the block itself does not enforce this.
`include "base64_stream_decoder_defines.svh"

module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_char,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        message_end,
  output logic [15:0] byte_total,
  input  logic        limit_valid,
  output logic        limit_ready,
  input  logic [15:0] output_limit
);

  logic [7:0]          in_char;
  logic                in_full;
  logic [15:0]         limit;
  logic                go;
  logic                load;
  logic                out_free;
  b64sd_pkg::bundle_t  res;
  b64sd_pkg::result_t  cur;

  assign limit_ready = 1'b1;
  assign go          = in_full && (res.count == 2'd0 || out_free);
  assign load        = go && (res.count != 2'd0);
  assign text_stall  = in_full && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text_valid && !text_stall) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      in_char <= text_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 16'hFFFF;
    end else if (limit_valid && limit_ready) begin
      limit <= output_limit;
    end
  end

  b64sd_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .ch    (in_char),
    .limit (limit),
    .res   (res)
  );

  b64sd_out u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .res   (res),
    .stall (result_stall),
    .valid (result_valid),
    .free  (out_free),
    .cur   (cur)
  );

  assign data_byte   = cur.data_byte;
  assign byte_valid  = cur.byte_valid;
  assign run_last    = cur.run_last;
  assign message_end = cur.message_end;
  assign byte_total  = cur.byte_total;

  `B64SD_ASSERT_NOW(a_end_is_last, clk, rst, result_valid && message_end, run_last)
  `B64SD_ASSERT_NOW(a_empty_is_end, clk, rst, result_valid && !byte_valid,
    message_end && data_byte == 8'h00)
  `B64SD_ASSERT_NEXT(a_run_continues, clk, rst,
    result_valid && !result_stall && !run_last, result_valid && byte_valid)

endmodule
